// ===== rtl/core/sps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, constants and helpers of the stream pattern substitute block.
// ----------------------------------------------------------------------------
package sps_pkg;

   localparam int PATTERN_MAX = 8;
   localparam int REPL_MAX    = 8;
   localparam int HOLD_DEPTH  = 8;
   localparam int ADDR_W      = 3;
   localparam int LEN_W       = 4;
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 64;
   localparam int CSR_IDX_W   = 2;

   localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_BYTES  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_LENGTH = 2'd3;

   typedef struct packed {
      logic [WORD_W-1:0] pattern_bytes;
      logic [LEN_W-1:0]  pattern_length;
      logic [WORD_W-1:0] replacement_bytes;
      logic [LEN_W-1:0]  replacement_length;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_last;
      logic              stream_done;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type res;
   } push_type;

   function automatic logic [BYTE_W-1:0] byte_of(input logic [WORD_W-1:0] word,
                                                 input logic [ADDR_W-1:0] idx);
      byte_of = word[{idx, 3'b000} +: BYTE_W];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/stream_pattern_substitute.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stream_pattern_substitute
// Byte stream find-and-replace with held prefix bytes kept in a small memory.
// ----------------------------------------------------------------------------
// sequence: accept, scan of the held and new bytes, one decide step, then
//   a memory read and a push per released byte and a push per replacement byte
// throughput: one request at a time; requests stall until the current byte's
//   scan, release and replacement are done
// reset: synchronous; configuration zero, nothing held, output register empty;
//   the held-byte memory is not cleared
module stream_pattern_substitute (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [sps_pkg::BYTE_W-1:0]      req_in_byte,
   input  wire logic                            req_stream_end,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [sps_pkg::BYTE_W-1:0]           rsp_out_byte,
   output logic                                 rsp_run_last,
   output logic                                 rsp_stream_done,
   input  wire logic                            csr_wr_en,
   input  wire logic [sps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sps_pkg::WORD_W-1:0]      csr_wr_data
);

   sps_pkg::cfg_type  cfg;
   sps_pkg::push_type push;
   logic              out_free;

   sps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   sps_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_stream_end (req_stream_end),
      .cfg            (cfg),
      .out_free       (out_free),
      .push           (push)
   );

   sps_out_stage u_out (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_done (rsp_stream_done)
   );

endmodule
`default_nettype wire

// ===== rtl/core/sps_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sps_csr
// Configuration registers; lengths are clamped to their maximum.
// ----------------------------------------------------------------------------
module sps_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [sps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sps_pkg::WORD_W-1:0]        csr_wr_data,
   output sps_pkg::cfg_type                       cfg
);

   logic [sps_pkg::WORD_W-1:0] pattern_bytes_ff, pattern_bytes_in;
   logic [sps_pkg::LEN_W-1:0]  pattern_length_ff, pattern_length_in;
   logic [sps_pkg::WORD_W-1:0] replacement_bytes_ff, replacement_bytes_in;
   logic [sps_pkg::LEN_W-1:0]  replacement_length_ff, replacement_length_in;

   always_comb begin
      pattern_bytes_in      = pattern_bytes_ff;
      pattern_length_in     = pattern_length_ff;
      replacement_bytes_in  = replacement_bytes_ff;
      replacement_length_in = replacement_length_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            sps_pkg::CSR_PATTERN_BYTES: begin
               pattern_bytes_in = csr_wr_data;
            end
            sps_pkg::CSR_PATTERN_LENGTH: begin
               pattern_length_in = csr_wr_data[sps_pkg::LEN_W-1:0];
            end
            sps_pkg::CSR_REPLACEMENT_BYTES: begin
               replacement_bytes_in = csr_wr_data;
            end
            sps_pkg::CSR_REPLACEMENT_LENGTH: begin
               replacement_length_in = csr_wr_data[sps_pkg::LEN_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= '0;
         pattern_length_ff     <= '0;
         replacement_bytes_ff  <= '0;
         replacement_length_ff <= '0;
      end else begin
         pattern_bytes_ff      <= pattern_bytes_in;
         pattern_length_ff     <= pattern_length_in;
         replacement_bytes_ff  <= replacement_bytes_in;
         replacement_length_ff <= replacement_length_in;
      end
   end

   always_comb begin
      cfg.pattern_bytes     = pattern_bytes_ff;
      cfg.replacement_bytes = replacement_bytes_ff;
      cfg.pattern_length    = (pattern_length_ff > sps_pkg::LEN_W'(sps_pkg::PATTERN_MAX)) ?
                              sps_pkg::LEN_W'(sps_pkg::PATTERN_MAX) : pattern_length_ff;
      cfg.replacement_length = (replacement_length_ff > sps_pkg::LEN_W'(sps_pkg::REPL_MAX)) ?
                               sps_pkg::LEN_W'(sps_pkg::REPL_MAX) : replacement_length_ff;
   end

endmodule
`default_nettype wire

// ===== rtl/core/sps_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sps_out_stage
// Output register of the result channel; frees itself when taken.
// ----------------------------------------------------------------------------
module sps_out_stage (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire sps_pkg::push_type            push,
   output logic                              out_free,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [sps_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                              rsp_run_last,
   output logic                              rsp_stream_done
);

   logic                vld_ff, vld_in;
   sps_pkg::result_type res_ff;

   assign out_free = !vld_ff || !rsp_stall;
   assign vld_in   = push.valid || (vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         res_ff <= push.res;
      end
   end

   assign rsp_valid       = vld_ff;
   assign rsp_out_byte    = res_ff.out_byte;
   assign rsp_run_last    = res_ff.run_last;
   assign rsp_stream_done = res_ff.stream_done;

endmodule
`default_nettype wire

// ===== rtl/core/sps_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sps_ctrl
// Held-byte memory and sequencer: scans held bytes for the first start that
// is still a pattern prefix, then emits released bytes and replacements.
// ----------------------------------------------------------------------------
module sps_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [sps_pkg::BYTE_W-1:0]   req_in_byte,
   input  wire logic                         req_stream_end,
   input  wire sps_pkg::cfg_type             cfg,
   input  wire logic                         out_free,
   output sps_pkg::push_type                 push
);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_SCAN      = 6'b000010,
      ST_DECIDE    = 6'b000100,
      ST_EMIT_RD   = 6'b001000,
      ST_EMIT_WAIT = 6'b010000,
      ST_REPL      = 6'b100000
   } state_type;

   localparam int AW = sps_pkg::ADDR_W;
   localparam int LW = sps_pkg::LEN_W;
   localparam int HD = sps_pkg::HOLD_DEPTH;

   state_type state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic          end_ff, end_in;
   logic          nl_ff, nl_in;
   logic [LW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [AW-1:0] rd_pos_ff, rd_pos_in;
   logic [HD-1:0] alive_ff, alive_in;
   logic [LW-1:0] emit_n_ff, emit_n_in;
   logic [LW-1:0] repl_n_ff, repl_n_in;
   logic [LW-1:0] keep_n_ff, keep_n_in;
   logic [LW-1:0] ep_ff, ep_in;
   logic [LW-1:0] rp_ff, rp_in;

   // held-byte memory
   logic [sps_pkg::BYTE_W-1:0] hold_mem [HD];
   logic [sps_pkg::BYTE_W-1:0] mem_rdata_ff;
   logic                       mem_we;
   logic                       mem_re;
   logic [AW-1:0]              mem_waddr;
   logic [AW-1:0]              mem_raddr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hold_mem[mem_waddr] <= req_in_byte;
      end
      if (mem_re) begin
         mem_rdata_ff <= hold_mem[mem_raddr];
      end
   end

   assign mem_waddr = head_ff + cnt_ff[AW-1:0];

   // per-start prefix tracking
   logic [HD-1:0] alive_upd;
   always_comb begin
      logic [AW-1:0] diff;
      diff = '0;
      for (int s = 0; s < HD; s++) begin
         diff = rd_pos_ff - AW'(s);
         if (AW'(s) <= rd_pos_ff) begin
            alive_upd[s] = alive_ff[s] && ({1'b0, diff} < cfg.pattern_length) &&
                           (mem_rdata_ff == sps_pkg::byte_of(cfg.pattern_bytes, diff));
         end else begin
            alive_upd[s] = alive_ff[s];
         end
      end
   end

   // first start that is still a prefix
   logic          found;
   logic [LW-1:0] sstar;
   always_comb begin
      found = 1'b0;
      sstar = cnt_ff;
      for (int s = 0; s < HD; s++) begin
         if (!found && (LW'(s) < cnt_ff) && alive_ff[s]) begin
            found = 1'b1;
            sstar = LW'(s);
         end
      end
   end

   logic          match;
   logic          flush;
   logic [LW-1:0] emit_calc;
   logic [LW-1:0] repl_calc;
   logic [LW-1:0] keep_calc;
   logic          last_mem;
   logic          last_repl;
   logic          scan_last;

   assign match     = found && ((cnt_ff - sstar) == cfg.pattern_length);
   assign flush     = nl_ff || end_ff;
   assign emit_calc = (flush && !match) ? cnt_ff : sstar;
   assign repl_calc = match ? cfg.replacement_length : '0;
   assign keep_calc = (match || flush) ? '0 : (cnt_ff - sstar);
   assign last_mem  = (ep_ff == (emit_n_ff - LW'(1)));
   assign last_repl = (rp_ff == (repl_n_ff - LW'(1)));
   assign scan_last = ({1'b0, rd_pos_ff} == (cnt_ff - LW'(1)));

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      cnt_in    = cnt_ff;
      end_in    = end_ff;
      nl_in     = nl_ff;
      rd_idx_in = rd_idx_ff;
      rd_vld_in = rd_vld_ff;
      rd_pos_in = rd_pos_ff;
      alive_in  = alive_ff;
      emit_n_in = emit_n_ff;
      repl_n_in = repl_n_ff;
      keep_n_in = keep_n_ff;
      ep_in     = ep_ff;
      rp_in     = rp_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_raddr = head_ff + rd_idx_ff[AW-1:0];
      push      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mem_we    = 1'b1;
               cnt_in    = cnt_ff + LW'(1);
               end_in    = req_stream_end;
               nl_in     = (req_in_byte == sps_pkg::NEWLINE);
               rd_idx_in = '0;
               rd_vld_in = 1'b0;
               alive_in  = '1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_vld_in = 1'b0;
            if (rd_idx_ff < cnt_ff) begin
               mem_re    = 1'b1;
               mem_raddr = head_ff + rd_idx_ff[AW-1:0];
               rd_idx_in = rd_idx_ff + LW'(1);
               rd_vld_in = 1'b1;
               rd_pos_in = rd_idx_ff[AW-1:0];
            end
            if (rd_vld_ff) begin
               alive_in = alive_upd;
               if (scan_last) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            emit_n_in = emit_calc;
            repl_n_in = repl_calc;
            keep_n_in = keep_calc;
            ep_in     = '0;
            rp_in     = '0;
            if (emit_calc != '0) begin
               state_in = ST_EMIT_RD;
            end else if (repl_calc != '0) begin
               state_in = ST_REPL;
            end else begin
               head_in  = head_ff + emit_calc[AW-1:0];
               cnt_in   = keep_calc;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            mem_re    = 1'b1;
            mem_raddr = head_ff + ep_ff[AW-1:0];
            state_in  = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (out_free) begin
               push.valid           = 1'b1;
               push.res.out_byte    = mem_rdata_ff;
               push.res.run_last    = last_mem && (repl_n_ff == '0);
               push.res.stream_done = last_mem && (repl_n_ff == '0) && end_ff;
               ep_in = ep_ff + LW'(1);
               if (!last_mem) begin
                  state_in = ST_EMIT_RD;
               end else if (repl_n_ff != '0) begin
                  state_in = ST_REPL;
               end else begin
                  head_in  = head_ff + emit_n_ff[AW-1:0];
                  cnt_in   = keep_n_ff;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REPL: begin
            if (out_free) begin
               push.valid           = 1'b1;
               push.res.out_byte    = sps_pkg::byte_of(cfg.replacement_bytes, rp_ff[AW-1:0]);
               push.res.run_last    = last_repl;
               push.res.stream_done = last_repl && end_ff;
               rp_in = rp_ff + LW'(1);
               if (last_repl) begin
                  head_in  = head_ff + emit_n_ff[AW-1:0];
                  cnt_in   = keep_n_ff;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         cnt_ff    <= cnt_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff    <= end_in;
      nl_ff     <= nl_in;
      rd_idx_ff <= rd_idx_in;
      rd_pos_ff <= rd_pos_in;
      alive_ff  <= alive_in;
      emit_n_ff <= emit_n_in;
      repl_n_ff <= repl_n_in;
      keep_n_ff <= keep_n_in;
      ep_ff     <= ep_in;
      rp_ff     <= rp_in;
   end

   a_hold_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> cnt_ff < LW'(sps_pkg::PATTERN_MAX))
      else $error("held count exceeds pattern room");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> out_free)
      else $error("result pushed into a busy output register");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> (state_ff == ST_SCAN && cnt_ff != '0))
      else $error("accepted request did not start a scan");

   a_read_pos: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> ({1'b0, rd_pos_ff} < cnt_ff))
      else $error("scan read beyond held bytes");

endmodule
`default_nettype wire

// ===== tb/sv/tb_stream_pattern_substitute.sv =====
// ----------------------------------------------------------------------------
// tb_stream_pattern_substitute
// Self-checking bench for the byte stream find-and-replace block. A short
// scripted sequence walks the corner cases, then random text is pushed through
// several pattern and replacement settings. Every output byte is compared
// with a cycle-free predictor of the substitution or a hand-written
// expectation, under random request gaps and response back-pressure.
// ----------------------------------------------------------------------------
module tb_stream_pattern_substitute;
   import sps_pkg::*;

   localparam int CLOCK_HALF    = 2;
   localparam int SETTLE_CYCLES = 48;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 56;

   typedef struct packed {
      logic              is_settings;
      logic [WORD_W-1:0] pat;
      logic [LEN_W-1:0]  pat_len;
      logic [WORD_W-1:0] rep;
      logic [LEN_W-1:0]  rep_len;
      logic [BYTE_W-1:0] text;
      logic              last;
      logic              typed;
      logic [BYTE_W-1:0] want_byte;
   } script_entry_type;

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_in_byte     = '0;
   logic                 req_stream_end  = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [BYTE_W-1:0]    rsp_out_byte;
   logic                 rsp_run_last;
   logic                 rsp_stream_done;
   logic                 csr_wr_en       = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index       = CSR_PATTERN_BYTES;
   logic [WORD_W-1:0]    csr_wr_data     = '0;

   // hand-written expectation travelling with the request
   logic                 req_typed       = 1'b0;
   result_type           req_typed_res   = '0;

   cfg_type              shadow_cfg      = '0;
   logic [BYTE_W-1:0]    held_text [PATTERN_MAX];
   int unsigned          held_len        = 0;
   result_type           fresh_results[$];
   result_type           due_results[$];
   result_type           awaited;
   script_entry_type     script[$];

   int                   failures        = 0;
   int                   requests_sent   = 0;
   int                   results_seen    = 0;
   int                   streams_closed  = 0;
   int                   settings_used   = 0;
   int                   cycle_count     = 0;
   int                   stall_left      = 0;
   int                   stall_pick;
   bit                   calm            = 1'b0;

   stream_pattern_substitute dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_stream_end  (req_stream_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_done (rsp_stream_done),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   function automatic void queue_text(input logic [BYTE_W-1:0] b);
      fresh_results.push_back(result_type'{out_byte: b, run_last: 1'b0, stream_done: 1'b0});
   endfunction

   task automatic substitute_byte(input logic [BYTE_W-1:0] b, input logic last);
      logic [BYTE_W-1:0] work [PATTERN_MAX+1];
      int unsigned       plen;
      int unsigned       rlen;
      int unsigned       n;
      int unsigned       i;
      bit                prefix;
      bit                scanning;
      fresh_results.delete();
      plen = (shadow_cfg.pattern_length > PATTERN_MAX) ? PATTERN_MAX
                                                       : shadow_cfg.pattern_length;
      rlen = (shadow_cfg.replacement_length > REPL_MAX) ? REPL_MAX
                                                         : shadow_cfg.replacement_length;
      n = (held_len > PATTERN_MAX - 1) ? PATTERN_MAX - 1 : held_len;
      for (i = 0; i < n; i++) work[i] = held_text[i];
      work[n] = b;
      n++;
      scanning = 1'b1;
      while (scanning && n > 0) begin
         prefix = (n <= plen);
         for (i = 0; i < n; i++)
            if (work[i] != shadow_cfg.pattern_bytes[i*BYTE_W +: BYTE_W]) prefix = 1'b0;
         if (prefix) begin
            scanning = 1'b0;
            if (n == plen) begin
               for (i = 0; i < rlen; i++)
                  queue_text(shadow_cfg.replacement_bytes[i*BYTE_W +: BYTE_W]);
               n = 0;
            end
         end else begin
            queue_text(work[0]);
            for (i = 1; i < n; i++) work[i-1] = work[i];
            n--;
         end
      end
      // newline or end of stream flushes what is held
      if (b == NEWLINE || last) begin
         for (i = 0; i < n; i++) queue_text(work[i]);
         n = 0;
      end
      held_len = n;
      for (i = 0; i < n; i++) held_text[i] = work[i];
      if (fresh_results.size() > 0) begin
         fresh_results[fresh_results.size()-1].run_last    = 1'b1;
         fresh_results[fresh_results.size()-1].stream_done = last;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && csr_wr_en) begin
         case (csr_index)
            CSR_PATTERN_BYTES:      shadow_cfg.pattern_bytes      = csr_wr_data;
            CSR_PATTERN_LENGTH:     shadow_cfg.pattern_length     = csr_wr_data[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  shadow_cfg.replacement_bytes  = csr_wr_data;
            CSR_REPLACEMENT_LENGTH: shadow_cfg.replacement_length = csr_wr_data[LEN_W-1:0];
            default: ;
         endcase
      end
      if (!reset && req_valid && !req_stall) begin
         substitute_byte(req_in_byte, req_stream_end);
         if (req_typed) due_results.push_back(req_typed_res);
         else foreach (fresh_results[k]) due_results.push_back(fresh_results[k]);
         requests_sent++;
         if (req_stream_end) streams_closed++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (due_results.size() == 0) begin
            $display("%0t unexpected result byte %02h", $time, rsp_out_byte);
            failures++;
         end else begin
            awaited = due_results.pop_front();
            if (rsp_out_byte !== awaited.out_byte) begin
               $display("%0t out_byte expected %02h got %02h", $time,
                        awaited.out_byte, rsp_out_byte);
               failures++;
            end
            if (rsp_run_last !== awaited.run_last) begin
               $display("%0t run_last expected %0b got %0b", $time,
                        awaited.run_last, rsp_run_last);
               failures++;
            end
            if (rsp_stream_done !== awaited.stream_done) begin
               $display("%0t stream_done expected %0b got %0b", $time,
                        awaited.stream_done, rsp_stream_done);
               failures++;
            end
         end
      end
   end

   // response back-pressure: runs of ready and stalled cycles
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_pick = $urandom_range(99);
         if (stall_pick < 55) begin
            rsp_stall  <= 1'b0;
            stall_left = $urandom_range(8, 1) - 1;
         end else if (stall_pick < 90) begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(3, 1) - 1;
         end else begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(30, 8) - 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  due_results.size());
         $display("stream_pattern_substitute: mismatch");
         $finish;
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                            input logic typed, input result_type typed_res);
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_stream_end <= last;
      req_typed      <= typed;
      req_typed_res  <= typed_res;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic sender_pause();
      int gap;
      int pick;
      pick = $urandom_range(99);
      if (calm || pick < 60) gap = 0;
      else if (pick < 90) gap = $urandom_range(3, 1);
      else if (pick < 98) gap = $urandom_range(10, 4);
      else gap = $urandom_range(40, 20);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_settings(input logic [WORD_W-1:0] pat, input logic [LEN_W-1:0] pat_len,
                                 input logic [WORD_W-1:0] rep, input logic [LEN_W-1:0] rep_len);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_PATTERN_BYTES;
      csr_wr_data <= pat;
      @(posedge clock);
      csr_index   <= CSR_PATTERN_LENGTH;
      csr_wr_data <= WORD_W'(pat_len);
      @(posedge clock);
      csr_index   <= CSR_REPLACEMENT_BYTES;
      csr_wr_data <= rep;
      @(posedge clock);
      csr_index   <= CSR_REPLACEMENT_LENGTH;
      csr_wr_data <= WORD_W'(rep_len);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings_used++;
   endtask

   function automatic void add_byte(input logic [BYTE_W-1:0] b, input logic last);
      script_entry_type e;
      e      = '0;
      e.text = b;
      e.last = last;
      script.push_back(e);
   endfunction

   function automatic void add_checked(input logic [BYTE_W-1:0] b, input logic last,
                                       input logic [BYTE_W-1:0] want);
      script_entry_type e;
      e           = '0;
      e.text      = b;
      e.last      = last;
      e.typed     = 1'b1;
      e.want_byte = want;
      script.push_back(e);
   endfunction

   function automatic void add_settings(input logic [WORD_W-1:0] pat,
                                        input logic [LEN_W-1:0] pat_len,
                                        input logic [WORD_W-1:0] rep,
                                        input logic [LEN_W-1:0] rep_len);
      script_entry_type e;
      e             = '0;
      e.is_settings = 1'b1;
      e.pat         = pat;
      e.pat_len     = pat_len;
      e.rep         = rep;
      e.rep_len     = rep_len;
      script.push_back(e);
   endfunction

   initial begin
      logic [BYTE_W-1:0] alphabet [3];
      logic [BYTE_W-1:0] feed[$];
      logic [WORD_W-1:0] pat;
      logic [WORD_W-1:0] rep;
      logic [LEN_W-1:0]  pat_len;
      logic [LEN_W-1:0]  rep_len;
      logic [BYTE_W-1:0] b;
      int                eff_len;
      int                pick;
      int                sent;
      int                cut;

      // empty pattern after reset passes bytes through
      add_checked(8'h00, 1'b0, 8'h00);
      add_checked(8'hFF, 1'b1, 8'hFF);
      add_checked(NEWLINE, 1'b0, NEWLINE);
      // "ab" -> "XYZ"
      add_settings(64'h6261, 4'd2, 64'h5A5958, 4'd3);
      add_byte(8'h61, 1'b0);
      add_byte(8'h62, 1'b0);
      add_byte(8'h61, 1'b0);
      add_byte(8'h61, 1'b0);
      add_byte(8'h63, 1'b0);
      add_byte(8'h61, 1'b0);
      add_byte(NEWLINE, 1'b0);
      add_checked(8'h61, 1'b1, 8'h61);
      // held byte meets an over-long pattern and replacement
      add_byte(8'h61, 1'b0);
      add_settings(64'h6161_6161_6161_6161, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
      repeat (7) add_byte(8'h61, 1'b0);
      // held byte no longer matches; pattern ends in newline, empty replacement
      add_byte(8'h61, 1'b0);
      add_settings(64'h0A62, 4'd2, 64'h0, 4'd0);
      add_byte(8'h62, 1'b0);
      add_byte(NEWLINE, 1'b0);
      add_byte(8'h62, 1'b0);
      add_byte(NEWLINE, 1'b1);
      add_checked(8'h7A, 1'b1, 8'h7A);
      // pattern disabled while a byte is held
      add_byte(8'h62, 1'b0);
      add_settings(64'h0A62, 4'd0, 64'h0, 4'd0);
      add_byte(8'h71, 1'b0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[k]) begin
         if (script[k].is_settings) begin
            write_settings(script[k].pat, script[k].pat_len, script[k].rep, script[k].rep_len);
         end else begin
            send_byte(script[k].text, script[k].last, script[k].typed,
                      result_type'{out_byte: script[k].want_byte, run_last: 1'b1,
                                   stream_done: script[k].last});
            sender_pause();
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin pat_len = 4'd8; rep_len = 4'd8; end
            1: begin pat_len = 4'd1; rep_len = 4'd0; end
            2: begin pat_len = 4'd0; rep_len = LEN_W'($urandom_range(8)); end
            3: begin
               pat_len = LEN_W'($urandom_range(15, 9));
               rep_len = LEN_W'($urandom_range(15, 9));
            end
            default: begin
               pat_len = LEN_W'($urandom_range(8, 1));
               rep_len = LEN_W'($urandom_range(8));
            end
         endcase
         foreach (alphabet[i]) alphabet[i] = BYTE_W'($urandom_range(255));
         if ($urandom_range(3) == 0) alphabet[2] = NEWLINE;
         eff_len = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
         pat = {$urandom, $urandom};
         rep = {$urandom, $urandom};
         for (int i = 0; i < eff_len; i++) pat[i*BYTE_W +: BYTE_W] = alphabet[$urandom_range(2)];
         write_settings(pat, pat_len, rep, rep_len);
         calm = (phase == 3);
         feed.delete();
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (feed.size() == 0) begin
               pick = $urandom_range(99);
               if (eff_len > 0 && pick < 40) begin
                  for (int i = 0; i < eff_len; i++) feed.push_back(pat[i*BYTE_W +: BYTE_W]);
               end else if (eff_len > 1 && pick < 60) begin
                  cut = $urandom_range(eff_len - 1, 1);
                  for (int i = 0; i < cut; i++) feed.push_back(pat[i*BYTE_W +: BYTE_W]);
                  feed.push_back(alphabet[$urandom_range(2)]);
               end else if (pick < 85) begin
                  feed.push_back(alphabet[$urandom_range(2)]);
               end else if (pick < 93) begin
                  feed.push_back(NEWLINE);
               end else begin
                  feed.push_back(BYTE_W'($urandom_range(255)));
               end
            end
            b = feed.pop_front();
            send_byte(b, ($urandom_range(99) < 4), 1'b0, '0);
            sent++;
            sender_pause();
            if ($urandom_range(39) == 0) drain_results();
         end
         calm = 1'b0;
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (due_results.size() != 0) begin
         $display("%0t %0d expected result bytes never arrived", $time, due_results.size());
         failures++;
      end
      $display("covered %0d requests over %0d register settings, %0d streams closed",
               requests_sent, settings_used, streams_closed);
      $display("%0d output bytes compared, %0d failures", results_seen, failures);
      if (failures == 0) begin
         $display("stream_pattern_substitute: match");
      end else begin
         $display("stream_pattern_substitute: mismatch");
      end
      $finish;
   end

endmodule

// ===== stream_pattern_substitute.f =====
rtl/core/sps_pkg.sv
rtl/core/sps_csr.sv
rtl/core/sps_out_stage.sv
rtl/core/sps_ctrl.sv
rtl/core/stream_pattern_substitute.sv
tb/sv/tb_stream_pattern_substitute.sv
